// ===== design/assert_macros.svh =====
// Assertion macros shared by the sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define MRUS_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define MRUS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/mrus_pkg.sv =====
// Shared types and codes of the recency-ranked entry sorter.
`timescale 1ns / 1ps
package mrus_pkg;

    // Item kinds on the input channel.
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_MARK  = 2'd1,
        KIND_EMIT  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    // Configuration register indexes.
    localparam logic CFG_ENTRIES_IN_USE = 1'b0;
    localparam logic CFG_SORT_ENABLE    = 1'b1;

    // Fixed field widths of the ports.
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 4;
    localparam int KEYIN_W = 32;
    localparam int COUNT_W = 5;

endpackage

// ===== design/mrus_order_cmp.sv =====
// Shared order comparator: online entries first, then lower recency rank.
`timescale 1ns / 1ps
module mrus_order_cmp import mrus_pkg::*; #(
    parameter int RANK_W = 5
) (
    input  logic              cand_online,
    input  logic [RANK_W-1:0] cand_rank,
    input  logic              best_online,
    input  logic [RANK_W-1:0] best_rank,
    output logic              cand_first
);

    // Ties on both keys keep the earlier index, which the scan order gives.
    always_comb begin
        if (cand_online != best_online) begin
            cand_first = cand_online;
        end else begin
            cand_first = (cand_rank < best_rank);
        end
    end

endmodule

// ===== design/mru_ranked_entry_sorter_core.sv =====
// Top level of the recency-ranked entry sorter.
`timescale 1ns / 1ps
// The block holds a table of entries (key and online bit) and a most-recently-used list of
// keys. A write item, an unused kind and an out-of-range mark-used are each taken with no
// further work, and the block stays ready. A mark-used item searches the list one slot a
// cycle, moves its key to the front, and then runs like an emit item; a zero key skips both.
// An emit item ranks the table against the list one list slot a cycle, takes a preparation
// step, then picks each display row by scanning the active entries through one shared order
// comparator, one entry a cycle; with recency ordering disabled it shows the entries in
// index order instead. Each row waits on m_ready, and an empty table gives one row marked
// as having no entries. The block takes a new item only when the previous one is done.
module mru_ranked_entry_sorter_core import mrus_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int KEY_BITS    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [KIND_W-1:0]  s_kind,
    input  logic [INDEX_W-1:0] s_entry_index,
    input  logic [KEYIN_W-1:0] s_entry_key,
    input  logic               s_entry_online,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_row_entry,
    output logic               m_last_row,
    output logic               m_no_entries,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [COUNT_W-1:0] cfg_data
);
    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_RANK_INIT,
        ST_RANK,
        ST_PREP,
        ST_SCAN,
        ST_LOAD,
        ST_WAIT
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [COUNT_W-1:0] entries_reg;
    logic               sort_en_reg;

    // Entry table and recency list, one lane per entry.
    logic [KEY_BITS-1:0] tkey_reg   [MAX_ENTRIES];
    logic                tonl_reg   [MAX_ENTRIES];
    logic [KEY_BITS-1:0] rec_reg    [MAX_ENTRIES];
    logic [CNT_W-1:0]    rank_reg   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] done_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // Sequencer working registers.
    logic [KEY_BITS-1:0] key_reg;
    logic [IDX_W-1:0]    pos_reg;
    logic [IDX_W-1:0]    p_reg;
    logic [IDX_W-1:0]    k_reg;
    logic [IDX_W-1:0]    best_reg;
    logic                have_reg;
    logic                m_valid_reg;
    logic [INDEX_W-1:0]  m_row_reg;
    logic                m_last_reg;
    logic                m_none_reg;

    logic [CNT_W-1:0]    n_act;
    logic                cand_first;
    logic                cand_ok;
    logic [KEY_BITS-1:0] in_key;

    // Active entry count, clamped to the table size.
    assign n_act = (32'(entries_reg) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                    : CNT_W'(entries_reg);
    assign in_key = KEY_BITS'(s_entry_key);

    assign s_ready      = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_row_entry  = m_row_reg;
    assign m_last_row   = m_last_reg;
    assign m_no_entries = m_none_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= '0;
            sort_en_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_ENTRIES_IN_USE) begin
                entries_reg <= cfg_data;
            end else begin
                sort_en_reg <= cfg_data[0];
            end
        end
    end

    // The candidate of the selection scan is compared with the best so far.
    mrus_order_cmp #(.RANK_W(CNT_W)) u_cmp (
        .cand_online (tonl_reg[p_reg]),
        .cand_rank   (rank_reg[p_reg]),
        .best_online (tonl_reg[best_reg]),
        .best_rank   (rank_reg[best_reg]),
        .cand_first  (cand_first)
    );
    assign cand_ok = (32'(p_reg) < 32'(n_act)) && !done_reg[p_reg];

    // Sequencer: state, working registers and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
            done_reg    <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        case (kind_t'(s_kind))
                            KIND_WRITE: begin
                                if (32'(s_entry_index) < MAX_ENTRIES) begin
                                    tkey_reg[IDX_W'(s_entry_index)] <= in_key;
                                    tonl_reg[IDX_W'(s_entry_index)] <= s_entry_online;
                                end
                            end
                            KIND_MARK: begin
                                if (32'(s_entry_index) < 32'(n_act)) begin
                                    key_reg <= tkey_reg[IDX_W'(s_entry_index)];
                                    p_reg   <= '0;
                                    if (tkey_reg[IDX_W'(s_entry_index)] == '0) begin
                                        state_reg <= ST_RANK_INIT;
                                    end else if (cnt_reg == '0) begin
                                        pos_reg   <= '0;
                                        cnt_reg   <= CNT_W'(1);
                                        state_reg <= ST_SHIFT;
                                    end else begin
                                        state_reg <= ST_SEARCH;
                                    end
                                end
                            end
                            KIND_EMIT: begin
                                state_reg <= ST_RANK_INIT;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                // Look for the key in the list, one slot a cycle.
                ST_SEARCH: begin
                    if (rec_reg[p_reg] == key_reg) begin
                        pos_reg   <= p_reg;
                        state_reg <= ST_SHIFT;
                    end else if (32'(p_reg) + 1 >= 32'(cnt_reg)) begin
                        if (32'(cnt_reg) < MAX_ENTRIES) begin
                            pos_reg <= IDX_W'(cnt_reg);
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end else begin
                            pos_reg <= IDX_W'(MAX_ENTRIES - 1);
                        end
                        state_reg <= ST_SHIFT;
                    end else begin
                        p_reg <= p_reg + IDX_W'(1);
                    end
                end
                // Move the key to the front, sliding the newer slots back by one.
                ST_SHIFT: begin
                    for (int i = 1; i < MAX_ENTRIES; i++) begin
                        if (i <= 32'(pos_reg)) begin
                            rec_reg[i] <= rec_reg[i-1];
                        end
                    end
                    rec_reg[0] <= key_reg;
                    state_reg  <= ST_RANK_INIT;
                end
                // Unlisted keys rank after every listed key.
                ST_RANK_INIT: begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        rank_reg[i] <= cnt_reg;
                    end
                    if (cnt_reg == '0) begin
                        state_reg <= ST_PREP;
                    end else begin
                        p_reg     <= IDX_W'(cnt_reg - CNT_W'(1));
                        state_reg <= ST_RANK;
                    end
                end
                // Walk the list from the oldest slot so the newest match wins.
                ST_RANK: begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (tkey_reg[i] == rec_reg[p_reg]) begin
                            rank_reg[i] <= CNT_W'(p_reg);
                        end
                    end
                    if (p_reg == '0) begin
                        state_reg <= ST_PREP;
                    end else begin
                        p_reg <= p_reg - IDX_W'(1);
                    end
                end
                ST_PREP: begin
                    done_reg <= '0;
                    k_reg    <= '0;
                    p_reg    <= '0;
                    have_reg <= 1'b0;
                    if (n_act == '0) begin
                        m_row_reg   <= '0;
                        m_last_reg  <= 1'b1;
                        m_none_reg  <= 1'b1;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_WAIT;
                    end else begin
                        state_reg <= ST_SCAN;
                    end
                end
                // Pick the best remaining entry, one candidate a cycle; with sorting off, take the next index.
                ST_SCAN: begin
                    if (!sort_en_reg) begin
                        best_reg  <= k_reg;
                        state_reg <= ST_LOAD;
                    end else begin
                        if (cand_ok && (!have_reg || cand_first)) begin
                            best_reg <= p_reg;
                            have_reg <= 1'b1;
                        end
                        if (32'(p_reg) + 1 >= 32'(n_act)) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            p_reg <= p_reg + IDX_W'(1);
                        end
                    end
                end
                ST_LOAD: begin
                    m_row_reg           <= INDEX_W'(best_reg);
                    m_last_reg          <= (32'(k_reg) + 1 == 32'(n_act));
                    m_none_reg          <= 1'b0;
                    m_valid_reg         <= 1'b1;
                    done_reg[best_reg]  <= 1'b1;
                    state_reg           <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        if (m_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            k_reg     <= k_reg + IDX_W'(1);
                            p_reg     <= '0;
                            have_reg  <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A result is only ever shown while the sequencer waits for it.
    `MRUS_ASSERT_IMPL(a_valid_in_wait, aclk, aresetn, m_valid_reg, state_reg == ST_WAIT)
    // The recency list never holds more keys than it has slots.
    `MRUS_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, 32'(cnt_reg) <= MAX_ENTRIES)
    // An empty-table result is always the last row of its run.
    `MRUS_ASSERT_IMPL(a_empty_last, aclk, aresetn, m_valid_reg && m_none_reg, m_last_reg)

endmodule
